FILE: hw/rtl/rrs_pkg.sv
// Shared types and constants for the RR interval uniform resampler.
// No dependencies; every other file in hw/rtl imports this package.
package rrs_pkg;

  localparam int TIME_W       = 32;
  localparam int VAL_W        = 24;
  localparam int STEP_W       = 16;
  localparam int OUT_CAPACITY = 64;
  localparam int CNT_W        = $clog2(OUT_CAPACITY + 1);
  localparam int PROD_W       = VAL_W + TIME_W;
  localparam int DIV_STEPS    = VAL_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int TDATA_W      = VAL_W + TIME_W;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd250;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul;
    logic div_start;
    logic emit_first;
    logic emit_sample;
    logic commit;
  } rrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_first;
    logic more;
    logic div_busy;
    logic out_free;
    logic last_sample;
  } rrs_sts_t;

endpackage

FILE: hw/rtl/rr_interval_uniform_resampler_top.sv
// Top level of the RR interval uniform resampler.
// Depends on rrs_pkg, rrs_ctrl and rrs_datapath.
//
// Beat points enter on the s_axis side and uniform grid samples leave on the
// m_axis side; one point is worked on at a time. A first point (after reset
// or with restart set) is loaded, checked and emitted as one sample. Each grid
// sample of a later point passes a multiply state, a divider start state, the
// 24 steps of the one-bit-per-cycle divider, a state that sees the divider
// done and an emit state; a point that produces no sample is only loaded,
// checked and committed. An emit waits while the output register still holds
// an unaccepted sample, so the receiver's stall holds up this sequence. The
// output register lets the next point be accepted while the final sample
// still waits. The user must write grid_step_ms through cfg_we and cfg_wdata
// only while the block is idle; the block does not enforce this. A value of
// zero acts as one.
module rr_interval_uniform_resampler_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rrs_pkg::STEP_W-1:0]   cfg_wdata,      // grid_step_ms
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [rrs_pkg::TDATA_W-1:0]  s_axis_tdata,   // point_time_ms, rr_value
  input  logic                         s_axis_tuser,   // restart
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rrs_pkg::TDATA_W-1:0]  m_axis_tdata,   // sample_time_ms, sample_value
  output logic                         m_axis_tlast,   // last
  output logic                         m_axis_tuser    // full_res
);
  import rrs_pkg::*;

  rrs_cmd_t cmd;
  rrs_sts_t sts;

  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrs_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_data    (s_axis_tdata),
    .in_restart (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_full   (m_axis_tuser)
  );

  // The sample that fills the capacity always ends its point's run.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("full sample without last");

  // A new point is never taken while the divider is still working.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !sts.div_busy)
    else $error("input accepted during division");

  // Only one command that loads the output register at a time.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_first && cmd.emit_sample))
    else $error("conflicting emit commands");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

FILE: hw/rtl/rrs_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on rrs_pkg. The quotient must fit in VAL_W bits.
module rrs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rrs_pkg::PROD_W-1:0]   dividend,
  input  logic [rrs_pkg::TIME_W-1:0]   divisor,
  output logic                         busy,
  output logic [rrs_pkg::VAL_W-1:0]    quot,
  output logic                         rem_nz
);
  import rrs_pkg::*;

  logic [TIME_W-1:0]    rem;
  logic [VAL_W-1:0]     dq;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 ge;

  // The upper dividend bits start as the partial remainder; they are already
  // below the divisor because the quotient fits in VAL_W bits.
  assign trial = {rem, dq[VAL_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= dividend[PROD_W-1:VAL_W];
      dq   <= dividend[VAL_W-1:0];
    end else if (busy) begin
      rem <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      dq  <= {dq[VAL_W-2:0], ge};
      cnt <= cnt + DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot   = dq;
  assign rem_nz = (rem != '0);

endmodule

FILE: hw/rtl/rrs_datapath.sv
// Datapath of the resampler: point and grid state, multiplier, divider and
// the output register. Depends on rrs_pkg and rrs_div.
module rrs_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  rrs_pkg::rrs_cmd_t            cmd,
  output rrs_pkg::rrs_sts_t            sts,
  input  logic                         cfg_we,
  input  logic [rrs_pkg::STEP_W-1:0]   cfg_wdata,
  input  logic [rrs_pkg::TDATA_W-1:0]  in_data,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rrs_pkg::TDATA_W-1:0]  out_data,
  output logic                         out_last,
  output logic                         out_full
);
  import rrs_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(OUT_CAPACITY);

  logic [STEP_W-1:0] grid_step;
  logic [TIME_W-1:0] prev_time;
  logic [VAL_W-1:0]  prev_value;
  logic [TIME_W-1:0] next_grid_time;
  logic [CNT_W-1:0]  emitted_count;
  logic              have_first;

  logic [TIME_W-1:0] t_in;
  logic [VAL_W-1:0]  v_in;
  logic              restart_in;
  logic [PROD_W-1:0] prod;
  logic              neg;

  logic [TIME_W-1:0] out_time;
  logic [VAL_W-1:0]  out_value;

  logic [STEP_W-1:0] step_eff;
  logic              dy_neg;
  logic [VAL_W-1:0]  dy_mag;
  logic [TIME_W-1:0] dx;
  logic [TIME_W-1:0] seg_len;
  logic [TIME_W-1:0] grid_time_next;
  logic [TIME_W-1:0] first_grid_time;
  logic [CNT_W-1:0]  count_next;
  logic [VAL_W-1:0]  quot;
  logic              rem_nz;
  logic              div_busy;
  logic [VAL_W-1:0]  sample_next;

  function automatic logic [TIME_W-1:0] grid_add(input logic [TIME_W-1:0] t,
                                                 input logic [STEP_W-1:0] s);
    logic [TIME_W:0] sum;
    sum = {1'b0, t} + (TIME_W + 1)'(s);
    grid_add = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

  assign step_eff        = (grid_step == '0) ? STEP_W'(1) : grid_step;
  assign dy_neg          = (v_in < prev_value);
  assign dy_mag          = dy_neg ? (prev_value - v_in) : (v_in - prev_value);
  assign dx              = (next_grid_time >= prev_time) ? (next_grid_time - prev_time) : '0;
  assign seg_len         = t_in - prev_time;
  assign grid_time_next  = grid_add(next_grid_time, step_eff);
  assign first_grid_time = grid_add(t_in, step_eff);
  assign count_next      = emitted_count + CNT_W'(1);

  // The sample always lies between the two point values, so no clamping is
  // needed. A negative slope rounds toward minus infinity.
  assign sample_next = neg ? (prev_value - quot - VAL_W'(rem_nz)) : (prev_value + quot);

  rrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (seg_len),
    .busy     (div_busy),
    .quot     (quot),
    .rem_nz   (rem_nz)
  );

  assign sts.is_first    = !have_first || restart_in;
  assign sts.more        = have_first && (t_in > prev_time) &&
                           (next_grid_time < t_in) && (emitted_count < CAP);
  assign sts.div_busy    = div_busy;
  assign sts.out_free    = !out_valid || out_ready;
  assign sts.last_sample = !((grid_time_next < t_in) && (count_next < CAP)) ||
                           (grid_time_next == next_grid_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_step      <= STEP_RESET;
      prev_time      <= '0;
      prev_value     <= '0;
      next_grid_time <= '0;
      emitted_count  <= '0;
      have_first     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        grid_step <= cfg_wdata;
      end
      if (cmd.emit_first) begin
        emitted_count  <= CNT_W'(1);
        next_grid_time <= first_grid_time;
      end else if (cmd.emit_sample) begin
        emitted_count  <= count_next;
        next_grid_time <= grid_time_next;
      end
      if (cmd.commit) begin
        prev_time  <= t_in;
        prev_value <= v_in;
        have_first <= 1'b1;
      end
      if (cmd.emit_first || cmd.emit_sample) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      t_in       <= in_data[TIME_W-1:0];
      v_in       <= in_data[TDATA_W-1:TIME_W];
      restart_in <= in_restart;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(dy_mag) * PROD_W'(dx);
      neg  <= dy_neg;
    end
    if (cmd.emit_first) begin
      out_time  <= t_in;
      out_value <= v_in;
      out_last  <= 1'b1;
      out_full  <= (CAP == CNT_W'(1));
    end else if (cmd.emit_sample) begin
      out_time  <= next_grid_time;
      out_value <= sample_next;
      out_last  <= sts.last_sample;
      out_full  <= (count_next >= CAP);
    end
  end

  assign out_data = {out_value, out_time};

endmodule

FILE: hw/rtl/rrs_ctrl.sv
// Controller state machine of the resampler: checks each beat point and
// sequences multiply, divide and emit per grid sample. Depends on rrs_pkg.
module rrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrs_pkg::rrs_sts_t sts,
  output rrs_pkg::rrs_cmd_t cmd
);
  import rrs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_FIRST  = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_first) begin
          state_next = S_FIRST;
        end else if (sts.more) begin
          state_next = S_MUL;
        end else begin
          // No grid sample falls in this segment; just remember the point.
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIRST: begin
        if (sts.out_free) begin
          cmd.emit_first = 1'b1;
          cmd.commit     = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_sample = 1'b1;
          if (sts.last_sample) begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
